>>> rtl/pswrm_pkg.sv
// Shared constants, codes and controller/datapath interface types for the
// per-source window rate monitor. No dependencies.
package pswrm_pkg;

    localparam int RING_DEPTH  = 256;
    localparam int RING_AW     = $clog2(RING_DEPTH);
    localparam int FILL_W      = $clog2(RING_DEPTH + 1);
    localparam int TABLE_DEPTH = 64;
    localparam int TAB_AW      = $clog2(TABLE_DEPTH);
    localparam int FLOOD_WINDOW = 5;
    localparam int RATE_WINDOW  = 2;

    localparam int TIME_W     = 32;
    localparam int ADDR_W     = 32;
    localparam int BYTES_W    = 16;
    localparam int CNT_W      = 9;
    localparam int CNT_MAX    = (2 ** CNT_W) - 1;
    localparam int PKT_W      = 32;
    localparam int BYTE_TOT_W = 48;
    localparam int WIN_W      = 8;
    localparam int THR_W      = 9;
    localparam int BLC_W      = 3;
    localparam int BL_NUM     = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Ring identifiers
    typedef logic [1:0] ring_id_t;
    localparam ring_id_t RING_SPIKE = 2'd0;
    localparam ring_id_t RING_FLOOD = 2'd1;
    localparam ring_id_t RING_RATE  = 2'd2;

    // Configuration register indexes
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    localparam cfg_idx_t CFG_WINDOW    = 3'd0;
    localparam cfg_idx_t CFG_SPIKE_THR = 3'd1;
    localparam cfg_idx_t CFG_FLOOD_THR = 3'd2;
    localparam cfg_idx_t CFG_BL_COUNT  = 3'd3;
    localparam cfg_idx_t CFG_BL_ADDR0  = 3'd4;
    localparam cfg_idx_t CFG_BL_ADDR1  = 3'd5;
    localparam cfg_idx_t CFG_BL_ADDR2  = 3'd6;
    localparam cfg_idx_t CFG_BL_ADDR3  = 3'd7;

    // Commands from controller to datapath
    typedef struct packed {
        logic     latch_in;     // capture input item, clear per-item flags
        ring_id_t ring;         // ring addressed by ring commands
        logic     ring_rd;      // read oldest slot of ring
        logic     pop;          // advance oldest slot of ring
        logic     keep;         // early eviction: keep current entry, flag overflow
        logic     push;         // write new slot of ring
        logic     cnt_rd;       // read count pair
        logic     cnt_from_idx; // count address is the item's entry
        logic     cnt_dec;      // write back decremented count of ring entry
        logic     cnt_inc;      // write back incremented counts of item's entry
        logic     key_rd;       // read key at scan index
        logic     scan_cmp;     // compare key, advance scan index
        logic     decide;       // pick entry, allocate if new
        logic     load_out;     // load result register
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic fill_zero;
        logic fill_full;
        logic aged;
        logic hit;
        logic scan_last;
        logic no_entry;
        logic out_free;
    } stat_t;

    function automatic logic [CNT_W-1:0] clip_count(input logic [FILL_W-1:0] c);
        logic [CNT_W-1:0] r;
        if (32'(c) > 32'(CNT_MAX)) begin
            r = '1;
        end else begin
            r = CNT_W'(c);
        end
        return r;
    endfunction

endpackage

>>> rtl/per_source_window_rate_monitor.sv
// Per-source sliding-window rate monitor, top level.
// Per item: purge of aged entries from the spike, flood and rate rings; scan of the source
// table (1..64 entries); push into the spike and flood rings, evicting early from a full one;
// count update; push into the rate ring; result load. A new source with no free entry skips
// the spike/flood pushes and count update. One item in work; the next is accepted from the cycle
// after the result loads, even while it waits. Reset (aresetn, sync, low): rings empty, totals 0.
module per_source_window_rate_monitor (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [pswrm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pswrm_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [pswrm_pkg::TIME_W-1:0]         s_packet_time,
    input  logic [pswrm_pkg::ADDR_W-1:0]         s_source_address,
    input  logic [pswrm_pkg::BYTES_W-1:0]        s_packet_bytes,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic                                 m_blacklisted,
    output logic                                 m_spike_alert,
    output logic [pswrm_pkg::CNT_W-1:0]          m_spike_count,
    output logic                                 m_flood_alert,
    output logic [pswrm_pkg::CNT_W-1:0]          m_flood_count,
    output logic [pswrm_pkg::CNT_W-1:0]          m_recent_packets,
    output logic [pswrm_pkg::PKT_W-1:0]          m_total_packets,
    output logic [pswrm_pkg::BYTE_TOT_W-1:0]     m_total_bytes,
    output logic                                 m_table_full,
    output logic                                 m_ring_overflow
);

    pswrm_pkg::cmd_t  cmd;
    pswrm_pkg::stat_t stat;

    // Sequencer
    pswrm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Datapath
    pswrm_dp u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_packet_time    (s_packet_time),
        .s_source_address (s_source_address),
        .s_packet_bytes   (s_packet_bytes),
        .cmd              (cmd),
        .stat             (stat),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_blacklisted    (m_blacklisted),
        .m_spike_alert    (m_spike_alert),
        .m_spike_count    (m_spike_count),
        .m_flood_alert    (m_flood_alert),
        .m_flood_count    (m_flood_count),
        .m_recent_packets (m_recent_packets),
        .m_total_packets  (m_total_packets),
        .m_total_bytes    (m_total_bytes),
        .m_table_full     (m_table_full),
        .m_ring_overflow  (m_ring_overflow)
    );

endmodule

>>> rtl/pswrm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pswrm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> rtl/pswrm_ctrl.sv
// Sequencing state machine of the rate monitor: purge, lookup, ring pushes,
// count update and result hand-off. Depends on pswrm_pkg.
module pswrm_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  pswrm_pkg::stat_t    stat,
    output pswrm_pkg::cmd_t     cmd
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_PCHK, ST_PRD, ST_PCNT, ST_LRD, ST_LCMP, ST_LDEC,
        ST_PUSH, ST_EVRD, ST_EVCNT, ST_PUSHW, ST_INC, ST_INCW, ST_RPUSH, ST_DONE
    } state_t;

    state_t              state_reg, state_next;
    pswrm_pkg::ring_id_t ring_reg, ring_next;

    assign s_ready = (state_reg == ST_IDLE);

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        ring_next  = ring_reg;
        cmd        = '0;
        cmd.ring   = ring_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.latch_in = 1'b1;
                    ring_next    = pswrm_pkg::RING_SPIKE;
                    state_next   = ST_PCHK;
                end
            end
            // Purge aged entries, one ring after another
            ST_PCHK: begin
                if (stat.fill_zero) begin
                    if (ring_reg == pswrm_pkg::RING_RATE) begin
                        state_next = ST_LRD;
                    end else begin
                        ring_next  = ring_reg + 2'd1;
                    end
                end else begin
                    cmd.ring_rd = 1'b1;
                    state_next  = ST_PRD;
                end
            end
            ST_PRD: begin
                if (!stat.aged) begin
                    if (ring_reg == pswrm_pkg::RING_RATE) begin
                        state_next = ST_LRD;
                    end else begin
                        ring_next  = ring_reg + 2'd1;
                        state_next = ST_PCHK;
                    end
                end else if (ring_reg == pswrm_pkg::RING_RATE) begin
                    cmd.pop    = 1'b1;
                    state_next = ST_PCHK;
                end else begin
                    cmd.cnt_rd = 1'b1;
                    state_next = ST_PCNT;
                end
            end
            ST_PCNT: begin
                cmd.cnt_dec = 1'b1;
                cmd.pop     = 1'b1;
                state_next  = ST_PCHK;
            end
            // Scan the source table
            ST_LRD: begin
                cmd.key_rd = 1'b1;
                state_next = ST_LCMP;
            end
            ST_LCMP: begin
                cmd.scan_cmp = 1'b1;
                if (stat.hit || stat.scan_last) begin
                    state_next = ST_LDEC;
                end else begin
                    state_next = ST_LRD;
                end
            end
            ST_LDEC: begin
                cmd.decide = 1'b1;
                if (stat.no_entry) begin
                    ring_next  = pswrm_pkg::RING_RATE;
                    state_next = ST_RPUSH;
                end else begin
                    ring_next  = pswrm_pkg::RING_SPIKE;
                    state_next = ST_PUSH;
                end
            end
            // Push into spike then flood ring, evicting early when full
            ST_PUSH: begin
                if (stat.fill_full) begin
                    cmd.ring_rd = 1'b1;
                    state_next  = ST_EVRD;
                end else begin
                    state_next  = ST_PUSHW;
                end
            end
            ST_EVRD: begin
                cmd.cnt_rd = 1'b1;
                state_next = ST_EVCNT;
            end
            ST_EVCNT: begin
                cmd.cnt_dec = 1'b1;
                cmd.keep    = 1'b1;
                cmd.pop     = 1'b1;
                state_next  = ST_PUSHW;
            end
            ST_PUSHW: begin
                cmd.push = 1'b1;
                if (ring_reg == pswrm_pkg::RING_SPIKE) begin
                    ring_next  = pswrm_pkg::RING_FLOOD;
                    state_next = ST_PUSH;
                end else begin
                    state_next = ST_INC;
                end
            end
            // Count the item for its source
            ST_INC: begin
                cmd.cnt_rd       = 1'b1;
                cmd.cnt_from_idx = 1'b1;
                state_next       = ST_INCW;
            end
            ST_INCW: begin
                cmd.cnt_inc = 1'b1;
                ring_next   = pswrm_pkg::RING_RATE;
                state_next  = ST_RPUSH;
            end
            ST_RPUSH: begin
                cmd.push = 1'b1;
                cmd.pop  = stat.fill_full;
                cmd.keep = stat.fill_full;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (stat.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ring_reg  <= pswrm_pkg::RING_SPIKE;
        end else begin
            state_reg <= state_next;
            ring_reg  <= ring_next;
        end
    end

endmodule

>>> rtl/pswrm_dp.sv
// Datapath of the rate monitor: configuration registers, ring and table
// memories, counters, totals and result register. Depends on pswrm_pkg, pswrm_ram.
module pswrm_dp (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [pswrm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pswrm_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic [pswrm_pkg::TIME_W-1:0]         s_packet_time,
    input  logic [pswrm_pkg::ADDR_W-1:0]         s_source_address,
    input  logic [pswrm_pkg::BYTES_W-1:0]        s_packet_bytes,
    input  pswrm_pkg::cmd_t                      cmd,
    output pswrm_pkg::stat_t                     stat,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic                                 m_blacklisted,
    output logic                                 m_spike_alert,
    output logic [pswrm_pkg::CNT_W-1:0]          m_spike_count,
    output logic                                 m_flood_alert,
    output logic [pswrm_pkg::CNT_W-1:0]          m_flood_count,
    output logic [pswrm_pkg::CNT_W-1:0]          m_recent_packets,
    output logic [pswrm_pkg::PKT_W-1:0]          m_total_packets,
    output logic [pswrm_pkg::BYTE_TOT_W-1:0]     m_total_bytes,
    output logic                                 m_table_full,
    output logic                                 m_ring_overflow
);

    localparam int RAW = pswrm_pkg::RING_AW;
    localparam int FW  = pswrm_pkg::FILL_W;
    localparam int TAW = pswrm_pkg::TAB_AW;
    localparam int TW  = pswrm_pkg::TIME_W;
    localparam int SRW = TW + TAW;

    // Configuration
    logic [pswrm_pkg::WIN_W-1:0]  cfg_window_reg;
    logic [pswrm_pkg::THR_W-1:0]  cfg_spike_thr_reg, cfg_flood_thr_reg;
    logic [pswrm_pkg::BLC_W-1:0]  cfg_bl_count_reg;
    logic [pswrm_pkg::ADDR_W-1:0] cfg_bl_addr_reg [pswrm_pkg::BL_NUM];

    // Item and per-item state
    logic [TW-1:0]                    now_reg;
    logic [pswrm_pkg::ADDR_W-1:0]     src_reg;
    logic [pswrm_pkg::BYTES_W-1:0]    bytes_reg;
    logic [TAW-1:0]                   scan_idx_reg, idx_reg, free_idx_reg;
    logic                             found_reg, free_valid_reg, full_reg, over_reg;
    logic [FW-1:0]                    s_cnt_reg, f_cnt_reg;

    // Ring pointers and table valid bits
    logic [RAW-1:0]                   head_reg [3];
    logic [RAW-1:0]                   tail_reg [3];
    logic [FW-1:0]                    fill_reg [3];
    logic [pswrm_pkg::TABLE_DEPTH-1:0] valid_reg;

    // Totals and result
    logic [pswrm_pkg::PKT_W-1:0]      pkt_total_reg;
    logic [pswrm_pkg::BYTE_TOT_W-1:0] byte_total_reg;
    logic                             m_valid_reg;

    // Memory signals
    logic [SRW-1:0]      spike_q, flood_q;
    logic [TW-1:0]       rate_q;
    logic [pswrm_pkg::ADDR_W-1:0] key_q;
    logic [2*FW-1:0]     cnt_q;
    logic [2*FW-1:0]     cnt_wdata;
    logic [TAW-1:0]      cnt_waddr, cnt_raddr;
    logic                cnt_we;

    logic [TW-1:0]       head_time, age, win;
    logic [TAW-1:0]      ring_src;
    logic [FW-1:0]       cur_fill;
    logic [FW-1:0]       cq_s, cq_f, dec_s, dec_f;
    logic                dec_free;
    logic                hit;
    logic                blk;
    logic [pswrm_pkg::PKT_W-1:0]      pkt_next;
    logic [pswrm_pkg::BYTE_TOT_W:0]   byte_sum;
    logic [pswrm_pkg::BYTE_TOT_W-1:0] byte_next;

    // Ring memories
    pswrm_ram #(.WIDTH(SRW), .DEPTH(pswrm_pkg::RING_DEPTH)) u_spike_ring (
        .aclk  (aclk),
        .we    (cmd.push && cmd.ring == pswrm_pkg::RING_SPIKE),
        .waddr (tail_reg[0]),
        .wdata ({now_reg, idx_reg}),
        .re    (cmd.ring_rd && cmd.ring == pswrm_pkg::RING_SPIKE),
        .raddr (head_reg[0]),
        .rdata (spike_q)
    );

    pswrm_ram #(.WIDTH(SRW), .DEPTH(pswrm_pkg::RING_DEPTH)) u_flood_ring (
        .aclk  (aclk),
        .we    (cmd.push && cmd.ring == pswrm_pkg::RING_FLOOD),
        .waddr (tail_reg[1]),
        .wdata ({now_reg, idx_reg}),
        .re    (cmd.ring_rd && cmd.ring == pswrm_pkg::RING_FLOOD),
        .raddr (head_reg[1]),
        .rdata (flood_q)
    );

    pswrm_ram #(.WIDTH(TW), .DEPTH(pswrm_pkg::RING_DEPTH)) u_rate_ring (
        .aclk  (aclk),
        .we    (cmd.push && cmd.ring == pswrm_pkg::RING_RATE),
        .waddr (tail_reg[2]),
        .wdata (now_reg),
        .re    (cmd.ring_rd && cmd.ring == pswrm_pkg::RING_RATE),
        .raddr (head_reg[2]),
        .rdata (rate_q)
    );

    // Source table: keys and count pairs {spike, flood}
    pswrm_ram #(.WIDTH(pswrm_pkg::ADDR_W), .DEPTH(pswrm_pkg::TABLE_DEPTH)) u_keys (
        .aclk  (aclk),
        .we    (cmd.decide && !found_reg && free_valid_reg),
        .waddr (free_idx_reg),
        .wdata (src_reg),
        .re    (cmd.key_rd),
        .raddr (scan_idx_reg),
        .rdata (key_q)
    );

    pswrm_ram #(.WIDTH(2*FW), .DEPTH(pswrm_pkg::TABLE_DEPTH)) u_counts (
        .aclk  (aclk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .re    (cmd.cnt_rd),
        .raddr (cnt_raddr),
        .rdata (cnt_q)
    );

    // Oldest entry of the selected ring and its age test
    always_comb begin
        case (cmd.ring)
            pswrm_pkg::RING_SPIKE: begin
                head_time = spike_q[SRW-1:TAW];
                ring_src  = spike_q[TAW-1:0];
                win       = TW'(cfg_window_reg);
                cur_fill  = fill_reg[0];
            end
            pswrm_pkg::RING_FLOOD: begin
                head_time = flood_q[SRW-1:TAW];
                ring_src  = flood_q[TAW-1:0];
                win       = TW'(pswrm_pkg::FLOOD_WINDOW);
                cur_fill  = fill_reg[1];
            end
            default: begin
                head_time = rate_q;
                ring_src  = '0;
                win       = TW'(pswrm_pkg::RATE_WINDOW);
                cur_fill  = fill_reg[2];
            end
        endcase
        age = now_reg - head_time;
    end

    // Count update: decrement for a dropped entry, clear for a new entry,
    // increment for the item
    always_comb begin
        cq_s  = cnt_q[2*FW-1:FW];
        cq_f  = cnt_q[FW-1:0];
        dec_s = cq_s;
        dec_f = cq_f;
        if (cmd.ring == pswrm_pkg::RING_SPIKE) begin
            if (cq_s != '0) dec_s = cq_s - FW'(1);
        end else begin
            if (cq_f != '0) dec_f = cq_f - FW'(1);
        end
        dec_free = (dec_s == '0) && (dec_f == '0) && !(cmd.keep && ring_src == idx_reg);
        cnt_raddr = cmd.cnt_from_idx ? idx_reg : ring_src;
        cnt_we    = cmd.cnt_dec || cmd.cnt_inc || (cmd.decide && !found_reg && free_valid_reg);
        if (cmd.cnt_dec) begin
            cnt_waddr = ring_src;
            cnt_wdata = {dec_s, dec_f};
        end else if (cmd.cnt_inc) begin
            cnt_waddr = idx_reg;
            cnt_wdata = {cq_s + FW'(1), cq_f + FW'(1)};
        end else begin
            cnt_waddr = free_idx_reg;
            cnt_wdata = '0;
        end
    end

    // Blacklist match, totals
    always_comb begin
        blk = 1'b0;
        for (int i = 0; i < pswrm_pkg::BL_NUM; i++) begin
            if (cfg_bl_count_reg > pswrm_pkg::BLC_W'(i) && cfg_bl_addr_reg[i] == src_reg) begin
                blk = 1'b1;
            end
        end
        pkt_next = (pkt_total_reg == '1) ? pkt_total_reg : pkt_total_reg + 1'b1;
        byte_sum = {1'b0, byte_total_reg} + (pswrm_pkg::BYTE_TOT_W + 1)'(bytes_reg);
        byte_next = byte_sum[pswrm_pkg::BYTE_TOT_W] ? '1
                                                     : byte_sum[pswrm_pkg::BYTE_TOT_W-1:0];
    end

    assign hit = valid_reg[scan_idx_reg] && (key_q == src_reg);

    // Status
    always_comb begin
        stat.fill_zero = (cur_fill == '0);
        stat.fill_full = (cur_fill == FW'(pswrm_pkg::RING_DEPTH));
        stat.aged      = (now_reg >= head_time) && (age >= win);
        stat.hit       = hit;
        stat.scan_last = (scan_idx_reg == TAW'(pswrm_pkg::TABLE_DEPTH - 1));
        stat.no_entry  = !found_reg && !free_valid_reg;
        stat.out_free  = !m_valid_reg || m_ready;
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_window_reg    <= pswrm_pkg::WIN_W'(10);
            cfg_spike_thr_reg <= pswrm_pkg::THR_W'(100);
            cfg_flood_thr_reg <= pswrm_pkg::THR_W'(50);
            cfg_bl_count_reg  <= '0;
            for (int i = 0; i < pswrm_pkg::BL_NUM; i++) cfg_bl_addr_reg[i] <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                pswrm_pkg::CFG_WINDOW:    cfg_window_reg    <= cfg_data[pswrm_pkg::WIN_W-1:0];
                pswrm_pkg::CFG_SPIKE_THR: cfg_spike_thr_reg <= cfg_data[pswrm_pkg::THR_W-1:0];
                pswrm_pkg::CFG_FLOOD_THR: cfg_flood_thr_reg <= cfg_data[pswrm_pkg::THR_W-1:0];
                pswrm_pkg::CFG_BL_COUNT:  cfg_bl_count_reg  <= cfg_data[pswrm_pkg::BLC_W-1:0];
                pswrm_pkg::CFG_BL_ADDR0:  cfg_bl_addr_reg[0] <= cfg_data;
                pswrm_pkg::CFG_BL_ADDR1:  cfg_bl_addr_reg[1] <= cfg_data;
                pswrm_pkg::CFG_BL_ADDR2:  cfg_bl_addr_reg[2] <= cfg_data;
                pswrm_pkg::CFG_BL_ADDR3:  cfg_bl_addr_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    // Item capture (payload, no reset)
    always_ff @(posedge aclk) begin
        if (cmd.latch_in) begin
            now_reg   <= s_packet_time;
            src_reg   <= s_source_address;
            bytes_reg <= s_packet_bytes;
        end
        if (cmd.scan_cmp && hit) begin
            idx_reg <= scan_idx_reg;
        end else if (cmd.decide && !found_reg) begin
            idx_reg <= free_idx_reg;
        end
        if (cmd.scan_cmp && !valid_reg[scan_idx_reg] && !free_valid_reg) begin
            free_idx_reg <= scan_idx_reg;
        end
        if (cmd.cnt_inc) begin
            s_cnt_reg <= cq_s + FW'(1);
            f_cnt_reg <= cq_f + FW'(1);
        end
    end

    // Per-item control flags and scan index
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_idx_reg   <= '0;
            found_reg      <= 1'b0;
            free_valid_reg <= 1'b0;
            full_reg       <= 1'b0;
            over_reg       <= 1'b0;
        end else if (cmd.latch_in) begin
            scan_idx_reg   <= '0;
            found_reg      <= 1'b0;
            free_valid_reg <= 1'b0;
            full_reg       <= 1'b0;
            over_reg       <= 1'b0;
        end else begin
            if (cmd.scan_cmp) begin
                scan_idx_reg <= scan_idx_reg + 1'b1;
                if (hit) found_reg <= 1'b1;
                if (!valid_reg[scan_idx_reg]) free_valid_reg <= 1'b1;
            end
            if (cmd.decide) full_reg <= !found_reg && !free_valid_reg;
            if (cmd.pop && cmd.keep) over_reg <= 1'b1;
        end
    end

    // Ring pointers: advance oldest on pop, newest on push
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < 3; k++) begin
                head_reg[k] <= '0;
                tail_reg[k] <= '0;
                fill_reg[k] <= '0;
            end
        end else begin
            for (int k = 0; k < 3; k++) begin
                if (cmd.ring == 2'(k)) begin
                    if (cmd.pop) begin
                        head_reg[k] <= (head_reg[k] == RAW'(pswrm_pkg::RING_DEPTH - 1))
                                       ? '0 : head_reg[k] + 1'b1;
                    end
                    if (cmd.push) begin
                        tail_reg[k] <= (tail_reg[k] == RAW'(pswrm_pkg::RING_DEPTH - 1))
                                       ? '0 : tail_reg[k] + 1'b1;
                    end
                    if (cmd.pop && !cmd.push && fill_reg[k] != '0) begin
                        fill_reg[k] <= fill_reg[k] - 1'b1;
                    end else if (cmd.push && !cmd.pop) begin
                        fill_reg[k] <= fill_reg[k] + 1'b1;
                    end
                end
            end
        end
    end

    // Table valid bits: free on zero counts, set on allocation
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (cmd.cnt_dec && dec_free) valid_reg[ring_src] <= 1'b0;
            if (cmd.decide && !found_reg && free_valid_reg) valid_reg[free_idx_reg] <= 1'b1;
        end
    end

    // Totals and result handshake
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pkt_total_reg  <= '0;
            byte_total_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cmd.load_out) begin
                pkt_total_reg  <= pkt_next;
                byte_total_reg <= byte_next;
                m_valid_reg    <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg    <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_blacklisted    <= blk;
            m_spike_alert    <= !full_reg && (32'(s_cnt_reg) >= 32'(cfg_spike_thr_reg));
            m_flood_alert    <= !full_reg && (32'(f_cnt_reg) >= 32'(cfg_flood_thr_reg));
            m_spike_count    <= full_reg ? '0 : pswrm_pkg::clip_count(s_cnt_reg);
            m_flood_count    <= full_reg ? '0 : pswrm_pkg::clip_count(f_cnt_reg);
            m_recent_packets <= pswrm_pkg::clip_count(fill_reg[2]);
            m_total_packets  <= pkt_next;
            m_total_bytes    <= byte_next;
            m_table_full     <= full_reg;
            m_ring_overflow  <= over_reg;
        end
    end

    assign m_valid = m_valid_reg;

endmodule
